>>> hw/rtl/lr_pkg.sv
// shared constants, codes and helpers for the line rasterizer
package lr_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 10;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // request kinds carried on the input tuser bit
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // width of one packed command:
  // {is_load, steep, minor_down, major_pos, major_end, minor_pos, major_span, minor_span}
  function automatic int cmd_width(input int coord_bits);
    cmd_width = 5 * coord_bits + 5;
  endfunction

endpackage

>>> hw/rtl/lr_front.sv
// front part: accepts items, sorts load endpoints by major axis and registers a command
module lr_front
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic [COORD_BITS-1:0]              ax,
  input  logic [COORD_BITS-1:0]              ay,
  input  logic [COORD_BITS-1:0]              bx,
  input  logic [COORD_BITS-1:0]              by,
  output logic                               cmd_valid,
  input  logic                               cmd_ready,
  output logic [cmd_width(COORD_BITS)-1:0]   cmd_data
);

  localparam int CW = COORD_BITS;
  localparam int CMDW = cmd_width(COORD_BITS);

  logic            x_gt, y_gt;
  logic [CW-1:0]   dx, dy;
  logic            steep;
  logic [CW-1:0]   mj0, mn0, mj1, mn1;
  logic [CW-1:0]   mj_lo, mj_hi, mn_lo, mn_hi;
  logic            do_swap;
  logic            mn_down;
  logic [CW-1:0]   mn_span;
  logic [CMDW-1:0] cmd_nxt;

  logic            valid_r;
  logic [CMDW-1:0] cmd_r;

  // absolute differences and axis choice
  always_comb begin
    x_gt  = ax > bx;
    y_gt  = ay > by;
    dx    = x_gt ? (ax - bx) : (bx - ax);
    dy    = y_gt ? (ay - by) : (by - ay);
    steep = dy > dx;
    if (steep) begin
      mj0 = ay; mn0 = ax; mj1 = by; mn1 = bx;
    end else begin
      mj0 = ax; mn0 = ay; mj1 = bx; mn1 = by;
    end
  end

  // order endpoints so the major coordinate rises
  always_comb begin
    do_swap = steep ? y_gt : x_gt;
    mj_lo   = do_swap ? mj1 : mj0;
    mj_hi   = do_swap ? mj0 : mj1;
    mn_lo   = do_swap ? mn1 : mn0;
    mn_hi   = do_swap ? mn0 : mn1;
    mn_down = !(mn_lo < mn_hi);
    mn_span = steep ? dx : dy;
    cmd_nxt = {(in_kind == REQ_LOAD), steep, mn_down, mj_lo, mj_hi, mn_lo,
               1'b0, (steep ? dy : dx), 1'b0, mn_span};
  end

  assign in_ready  = !valid_r || cmd_ready;
  assign cmd_valid = valid_r;
  assign cmd_data  = cmd_r;

  // command register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

>>> hw/rtl/lr_queue.sv
// small command queue that decouples front and back
module lr_queue
  import lr_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    count_r;
  logic             do_push, do_pop;

  assign push_ready = count_r != NW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // fill count never passes the depth
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= NW'(DEPTH))
    else $error("queue count beyond depth");

  // a pop alone lowers the count by one
  assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count not lowered on pop");

endmodule

>>> hw/rtl/lr_back.sv
// back part: holds the line state, steps the error term and registers pixels
module lr_back
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  logic [cmd_width(COORD_BITS)-1:0] cmd_data,
  output logic                             pix_valid,
  input  logic                             pix_ready,
  output logic [COORD_BITS-1:0]            pix_x,
  output logic [COORD_BITS-1:0]            pix_y,
  output logic                             pix_last
);

  localparam int CW = COORD_BITS;
  localparam int SW = COORD_BITS + 1;
  localparam int EW = COORD_BITS + 3;

  // command fields
  logic          c_load, c_steep, c_down;
  logic [CW-1:0] c_mj_pos, c_mj_end, c_mn_pos;
  logic [SW-1:0] c_mj_span, c_mn_span;

  // line state
  logic                 active_r, steep_r, down_r;
  logic [CW-1:0]        major_pos_r, major_end_r, minor_pos_r;
  logic [SW-1:0]        major_span_r, minor_span_r;
  logic signed [EW-1:0] error_r;

  // output register
  logic          out_valid_r, out_last_r;
  logic [CW-1:0] out_x_r, out_y_r;

  logic                 pop, emit, is_last, minor_move;
  logic signed [EW-1:0] err_sum;

  assign {c_load, c_steep, c_down, c_mj_pos, c_mj_end, c_mn_pos, c_mj_span, c_mn_span} =
    cmd_data;

  // pop whenever the output slot is free or being emptied
  assign cmd_ready = !out_valid_r || pix_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign emit      = pop && !c_load && active_r;
  assign is_last   = major_pos_r == major_end_r;

  // error update and midpoint test, 2*(err + minor_span) >= major_span
  always_comb begin
    err_sum    = error_r + $signed({2'b00, minor_span_r});
    minor_move = $signed({err_sum, 1'b0}) >= $signed({3'b000, major_span_r});
  end

  // line state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      steep_r      <= 1'b0;
      down_r       <= 1'b0;
      major_pos_r  <= '0;
      major_end_r  <= '0;
      minor_pos_r  <= '0;
      major_span_r <= '0;
      minor_span_r <= '0;
      error_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop && c_load) begin
        active_r     <= 1'b1;
        steep_r      <= c_steep;
        down_r       <= c_down;
        major_pos_r  <= c_mj_pos;
        major_end_r  <= c_mj_end;
        minor_pos_r  <= c_mn_pos;
        major_span_r <= c_mj_span;
        minor_span_r <= c_mn_span;
        error_r      <= '0;
      end else if (emit) begin
        if (is_last) begin
          active_r <= 1'b0;
        end else begin
          major_pos_r <= major_pos_r + 1'b1;
          if (minor_move) begin
            minor_pos_r <= down_r ? (minor_pos_r - 1'b1) : (minor_pos_r + 1'b1);
            error_r     <= err_sum - $signed({2'b00, major_span_r});
          end else begin
            error_r <= err_sum;
          end
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (pix_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (emit) begin
      out_x_r    <= steep_r ? minor_pos_r : major_pos_r;
      out_y_r    <= steep_r ? major_pos_r : minor_pos_r;
      out_last_r <= is_last;
    end
  end

  assign pix_valid = out_valid_r;
  assign pix_x     = out_x_r;
  assign pix_y     = out_y_r;
  assign pix_last  = out_last_r;

  // a pixel is only produced while a line is active
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(active_r))
    else $error("pixel emitted with no active line");

  // the final pixel ends the line
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_last && !(pop && c_load)) |=> !active_r)
    else $error("line still active after final pixel");

endmodule

>>> hw/rtl/line_rasterizer.sv
// line rasterizer top level: stream ports, front classifier, command queue, pixel stepper
// a step item passes the front command register, a queue slot and the output register in turn
// throughput: one item per clock unless stalled; the pixel stepper does one add, compare and subtract a cycle
// in_tready stays high while out_tready is high, except the first such cycle after a full queue
// reset (rst_n low, synchronous) empties the queue and output and leaves no line active
module line_rasterizer
  import lr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // start_x, start_y, end_x, end_y from the lowest bit up, zero padded to bytes
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]   in_tdata,
  // req_type
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // pixel_x, pixel_y from the lowest bit up, zero padded to bytes
  output logic [((2*COORD_BITS+7)/8)*8-1:0]   out_tdata,
  output logic                                out_tlast
);

  localparam int CW   = COORD_BITS;
  localparam int CMDW = cmd_width(COORD_BITS);
  localparam int OW   = ((2*COORD_BITS+7)/8)*8;

  logic            f_valid, f_ready, b_valid, b_ready;
  logic [CMDW-1:0] f_data, b_data;
  logic [CW-1:0]   px, py;

  // front: classify and sort endpoints
  lr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .ax        (in_tdata[CW-1:0]),
    .ay        (in_tdata[2*CW-1:CW]),
    .bx        (in_tdata[3*CW-1:2*CW]),
    .by        (in_tdata[4*CW-1:3*CW]),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_data)
  );

  // command queue
  lr_queue #(.WIDTH(CMDW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  // back: pixel stepper
  lr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd_data  (b_data),
    .pix_valid (out_tvalid),
    .pix_ready (out_tready),
    .pix_x     (px),
    .pix_y     (py),
    .pix_last  (out_tlast)
  );

  assign out_tdata = OW'({py, px});

endmodule
